// File: hw/rtl/g2enu_pkg.sv
// ----------------------------------------------------------------------------
// g2enu_pkg: shared constants and tables for the geodetic-to-ENU block
// Widths, config register indices, CORDIC arctangent table, arithmetic operation codes.
// ----------------------------------------------------------------------------
package g2enu_pkg;

    localparam int unsigned CordicStepsDefault = 24;
    localparam int unsigned AtanLen = 40;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW = 88;
    localparam int unsigned OutDataW = 112;

    localparam logic [CfgIdxW-1:0] RegRefLat = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRefLon = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRefAlt = 3'd2;
    localparam logic [CfgIdxW-1:0] RegOffE = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOffN = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRot = 3'd5;

    localparam logic signed [63:0] KQ29 = 64'sd326016437;
    localparam logic signed [63:0] E2Q36 = 64'sd460034291;
    localparam logic [63:0] AMm = 64'd6378137000;

    localparam int unsigned MulW = 64;

    function automatic logic [31:0] atan_tab(input logic [5:0] i);
        logic [31:0] r;
        begin
            case (i)
                6'd0: r = 32'h20000000;  6'd1: r = 32'h12E4051E;
                6'd2: r = 32'h09FB385B;  6'd3: r = 32'h051111D4;
                6'd4: r = 32'h028B0D43;  6'd5: r = 32'h0145D7E1;
                6'd6: r = 32'h00A2F61E;  6'd7: r = 32'h00517C55;
                6'd8: r = 32'h0028BE53;  6'd9: r = 32'h00145F2E;
                6'd10: r = 32'h000A2F98; 6'd11: r = 32'h000517CC;
                6'd12: r = 32'h00028BE6; 6'd13: r = 32'h000145F3;
                6'd14: r = 32'h0000A2F9; 6'd15: r = 32'h0000517C;
                6'd16: r = 32'h000028BE; 6'd17: r = 32'h0000145F;
                6'd18: r = 32'h00000A2F; 6'd19: r = 32'h00000517;
                6'd20: r = 32'h0000028B; 6'd21: r = 32'h00000145;
                6'd22: r = 32'h000000A2; 6'd23: r = 32'h00000051;
                6'd24: r = 32'h00000028; 6'd25: r = 32'h00000014;
                6'd26: r = 32'h0000000A; 6'd27: r = 32'h00000005;
                6'd28: r = 32'h00000002; 6'd29: r = 32'h00000001;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic        start;
        logic        vector_mode;
        logic [31:0] angle;
        logic signed [63:0] x0;
        logic signed [63:0] y0;
    } cordic_req_t;

    typedef struct packed {
        logic        start;
        logic [1:0]  kind;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  shift;
        logic        neg;
    } arith_req_t;

    localparam logic [1:0] OpMul = 2'd0;
    localparam logic [1:0] OpDiv = 2'd1;
    localparam logic [1:0] OpSqrt = 2'd2;

endpackage

// File: hw/rtl/g2enu_cordic.sv
// ----------------------------------------------------------------------------
// g2enu_cordic: shared CORDIC unit, one micro-rotation per cycle
// Rotation mode gives sin/cos in Q2.29 with quadrant fold; vectoring mode
// gives the angle of a non-negative normalized vector.
// ----------------------------------------------------------------------------
module g2enu_cordic #(
    parameter int unsigned CORDIC_STEPS = g2enu_pkg::CordicStepsDefault
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  g2enu_pkg::cordic_req_t   req,
    output logic                     done,
    output logic signed [63:0]       x_out,
    output logic signed [63:0]       y_out,
    output logic signed [63:0]       z_out
);
    import g2enu_pkg::*;

    localparam int unsigned NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

    logic               busy_reg, busy_next;
    logic               mode_reg;
    logic               flip_reg;
    logic [5:0]         i_reg;
    logic signed [63:0] x_reg, y_reg, z_reg;
    logic               done_reg;
    logic signed [63:0] tx, ty, zt;
    logic               dir;
    logic [31:0]        a_fold;
    logic               flip_in;

    assign flip_in = req.angle[31] ^ req.angle[30];
    assign a_fold  = flip_in ? (req.angle ^ 32'h80000000) : req.angle;
    assign tx      = x_reg >>> i_reg;
    assign ty      = y_reg >>> i_reg;
    assign zt      = {32'd0, atan_tab(i_reg)};
    assign dir     = mode_reg ? (y_reg >= 0) : (z_reg >= 0);
    assign busy_next = busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                mode_reg <= req.vector_mode;
                if (req.vector_mode) begin
                    flip_reg <= 1'b0;
                    x_reg    <= req.x0;
                    y_reg    <= req.y0;
                    z_reg    <= '0;
                end else begin
                    flip_reg <= flip_in;
                    x_reg    <= KQ29;
                    y_reg    <= '0;
                    z_reg    <= {{32{a_fold[31]}}, a_fold};
                end
            end else if (busy_next) begin
                if (i_reg == 6'(NSteps)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    i_reg <= i_reg + 6'd1;
                    if (mode_reg) begin
                        if (dir) begin
                            x_reg <= x_reg + ty; y_reg <= y_reg - tx; z_reg <= z_reg + zt;
                        end else begin
                            x_reg <= x_reg - ty; y_reg <= y_reg + tx; z_reg <= z_reg - zt;
                        end
                    end else begin
                        if (dir) begin
                            x_reg <= x_reg - ty; y_reg <= y_reg + tx; z_reg <= z_reg - zt;
                        end else begin
                            x_reg <= x_reg + ty; y_reg <= y_reg - tx; z_reg <= z_reg + zt;
                        end
                    end
                end
            end
        end
    end

    assign done  = done_reg;
    assign x_out = flip_reg ? -x_reg : x_reg;
    assign y_out = flip_reg ? -y_reg : y_reg;
    assign z_out = z_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("cordic done held");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> i_reg <= 6'(NSteps)) else $error("cordic index overrun");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg) else $error("cordic failed to start");

endmodule

// File: hw/rtl/g2enu_arith.sv
// ----------------------------------------------------------------------------
// g2enu_arith: bit-serial arithmetic unit
// Shift-add multiply with rounding, restoring divide, and integer square
// root; one bit per cycle to multiply or divide, a root digit on even counts.
// ----------------------------------------------------------------------------
module g2enu_arith (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  g2enu_pkg::arith_req_t   req,
    output logic                    done,
    output logic [63:0]             result
);
    import g2enu_pkg::*;

    logic         busy_reg;
    logic [1:0]   kind_reg;
    logic [6:0]   cnt_reg;
    logic [6:0]   sh_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  a_reg, b_reg, q_reg, res_reg;
    logic         done_reg;
    logic [127:0] prod_r;
    logic [64:0]  rem_try;
    logic [63:0]  sq_try;

    assign prod_r  = acc_reg + ((sh_reg == 7'd0) ? 128'd0 : (128'd1 << (sh_reg - 7'd1)));
    assign rem_try = {acc_reg[63:0], a_reg[63]} - {1'b0, b_reg};
    assign sq_try  = q_reg + b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                kind_reg <= req.kind;
                sh_reg   <= req.shift;
                neg_reg  <= req.neg;
                a_reg    <= req.a;
                b_reg    <= (req.kind == OpSqrt) ? 64'h4000000000000000 : req.b;
                acc_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    case (kind_reg)
                        OpMul: res_reg <= neg_reg ? -(64'(prod_r >> sh_reg))
                                                  : 64'(prod_r >> sh_reg);
                        default: res_reg <= q_reg;
                    endcase
                end else begin
                    cnt_reg <= cnt_reg - 7'd1;
                    case (kind_reg)
                        OpMul: begin
                            if (b_reg[0]) acc_reg <= acc_reg + ({64'd0, a_reg} << (7'd64 - cnt_reg));
                            b_reg <= b_reg >> 1;
                        end
                        OpDiv: begin
                            a_reg <= a_reg << 1;
                            if (!rem_try[64]) begin
                                acc_reg <= {64'd0, rem_try[63:0]};
                                q_reg   <= {q_reg[62:0], 1'b1};
                            end else begin
                                acc_reg <= {64'd0, acc_reg[62:0], a_reg[63]};
                                q_reg   <= {q_reg[62:0], 1'b0};
                            end
                        end
                        default: begin
                            if (cnt_reg[0] == 1'b0 && b_reg != 64'd0) begin
                                if (a_reg >= sq_try) begin
                                    a_reg <= a_reg - sq_try;
                                    q_reg <= (q_reg >> 1) + b_reg;
                                end else begin
                                    q_reg <= q_reg >> 1;
                                end
                                b_reg <= b_reg >> 2;
                            end
                        end
                    endcase
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("arith done held");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> (busy_reg && cnt_reg == 7'd64)) else $error("arith start");
    a_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("arith done while busy");

endmodule

// File: hw/rtl/geodetic_to_local_enu_heading.sv
// ----------------------------------------------------------------------------
// geodetic_to_local_enu_heading: GNSS fix to rotated local east/north, heading
// A sequencer drives one shared CORDIC and one bit-serial arithmetic unit.
//
//   channel   dir   payload (low bit first)
//   s_axis    in    latitude[30:0], longitude[62:31], altitude[87:63]
//   m_axis    out   east[31:0], north[63:32], heading[79:64], quat_z[95:80],
//                   quat_w[111:96]
//   cfg       in    cfg_wr, cfg_idx, cfg_data
//
// One request runs from accept to m_tvalid through 32 multiply, divide or root
// runs, 7 CORDIC runs, and the local-frame and heading normalization steps;
// normalization repeats while the vector still needs a shift, and a request
// with no movement skips one CORDIC run.
// One request is in work at a time; s_tready is high only while idle.
// A result held on m_tvalid holds the next request at its last step until taken.
// Reset is synchronous, active low, and clears control and previous position.
// ----------------------------------------------------------------------------
module geodetic_to_local_enu_heading #(
    parameter int unsigned CORDIC_STEPS = g2enu_pkg::CordicStepsDefault
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [g2enu_pkg::InDataW-1:0]   s_tdata,   // latitude, longitude, altitude
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [g2enu_pkg::OutDataW-1:0]  m_tdata,   // east, north, heading, quat_z, quat_w
    input  logic                            cfg_wr,
    input  logic [g2enu_pkg::CfgIdxW-1:0]   cfg_idx,
    input  logic [g2enu_pkg::CfgDataW-1:0]  cfg_data
);
    import g2enu_pkg::*;

    // sequencer states
    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_ISSUE = 6'd1;
    localparam logic [5:0] S_WAIT = 6'd2;
    localparam logic [5:0] S_OUT = 6'd3;

    localparam logic [2:0] UnitArith = 3'd0;
    localparam logic [2:0] UnitRot = 3'd1;
    localparam logic [2:0] UnitVec = 3'd2;
    localparam logic [2:0] UnitNorm = 3'd3;
    localparam logic [2:0] UnitLocal = 3'd4;

    localparam logic [6:0] PcPassEnd = 7'd12;
    localparam logic [6:0] PcLast = 7'd28;

    logic [5:0] st_reg;
    logic [6:0] pc_reg;

    logic signed [30:0] ref_lat_reg;
    logic signed [31:0] ref_lon_reg;
    logic signed [24:0] ref_alt_reg;
    logic signed [23:0] off_e_reg, off_n_reg;
    logic signed [15:0] rot_reg;
    logic signed [31:0] prev_e_reg, prev_n_reg;

    logic signed [63:0] v_reg [0:31];

    cordic_req_t creq;
    arith_req_t  areq;
    logic        cdone, adone;
    logic signed [63:0] cx, cy, cz;
    logic [63:0] ares;
    logic        m_valid_reg;
    logic [OutDataW-1:0] m_data_reg;

    g2enu_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk, .aresetn, .req(creq), .done(cdone), .x_out(cx), .y_out(cy), .z_out(cz)
    );
    g2enu_arith u_arith (.aclk, .aresetn, .req(areq), .done(adone), .result(ares));

    // micro-program operand helpers
    function automatic logic [63:0] mg(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v < -64'sd2147483648) return -64'sd2147483648;
        if (v > 64'sd2147483647) return 64'sd2147483647;
        return v;
    endfunction

    function automatic logic [15:0] q15(input logic signed [63:0] v);
        logic [63:0]        m;
        logic signed [63:0] r;
        m = (mg(v) + 64'd8192) >> 14;
        r = v[63] ? -signed'(m) : signed'(m);
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return r[15:0];
    endfunction

    logic signed [63:0] op_a, op_b;
    logic [1:0]  op_kind;
    logic [6:0]  op_sh;
    logic [2:0]  op_unit;
    logic [31:0] op_ang;
    logic [4:0]  op_dst;
    logic signed [63:0] sat_tmp;
    logic [4:0]  base;
    logic signed [63:0] src_lat, src_lon, src_alt;
    logic signed [63:0] dx, dy, dz, e_off, n_off, xr_w, yr_w, mx_w, my_w;
    logic        still;
    logic [31:0] z_cl, ang_q, ang_h, hsum;
    logic [63:0] norm_or;
    logic [6:0]  pc_next;
    logic [5:0]  st_adv;
    logic        phase_reg;
    logic        out_load;

    assign base    = phase_reg ? 5'd16 : 5'd8;
    assign src_lat = phase_reg ? v_reg[3] : v_reg[0];
    assign src_lon = phase_reg ? v_reg[4] : v_reg[1];
    assign src_alt = phase_reg ? v_reg[5] : v_reg[2];
    assign dx      = v_reg[13] - v_reg[21];
    assign dy      = v_reg[14] - v_reg[22];
    assign dz      = v_reg[15] - v_reg[23];
    assign e_off   = v_reg[24] - v_reg[25] - 64'(off_e_reg);
    assign n_off   = v_reg[28] - v_reg[29] - 64'(off_n_reg);
    assign xr_w    = sat32(v_reg[26] - v_reg[27]);
    assign yr_w    = sat32(v_reg[8] + v_reg[9]);
    assign mx_w    = xr_w - 64'(prev_e_reg);
    assign my_w    = yr_w - 64'(prev_n_reg);
    assign still   = (v_reg[14] == 64'sd0) && (v_reg[15] == 64'sd0);
    assign norm_or = unsigned'(v_reg[12]) | unsigned'(v_reg[13]);
    assign z_cl    = v_reg[16][63] ? 32'd0 :
                     ((v_reg[16] > 64'sd1073741824) ? 32'h40000000 : v_reg[16][31:0]);
    assign ang_q   = v_reg[14][63] ? (32'h80000000 - z_cl) : z_cl;
    assign ang_h   = still ? 32'd0 : (v_reg[15][63] ? (32'd0 - ang_q) : ang_q);
    assign hsum    = ang_h + 32'h00008000;
    assign pc_next = (pc_reg == PcPassEnd && !phase_reg) ? 7'd0 : pc_reg + 7'd1;
    assign st_adv  = (pc_reg == PcLast) ? S_OUT : S_ISSUE;
    assign out_load = (st_reg == S_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        op_a = '0; op_b = '0; op_kind = OpMul; op_sh = 7'd29; op_unit = UnitArith;
        op_ang = '0; op_dst = '0; sat_tmp = '0;
        case (pc_reg)
            7'd0: begin op_kind = OpDiv;
                  op_a = signed'((mg(src_lat) << 32) + 64'd1800000000);
                  op_b = 64'sd3600000000; op_dst = 5'd6; end
            7'd1: begin op_unit = UnitRot;
                  op_ang = src_lat[63] ? 32'd0 - v_reg[6][31:0] : v_reg[6][31:0];
                  op_dst = base; end
            7'd2: begin op_kind = OpDiv;
                  op_a = signed'((mg(src_lon) << 32) + 64'd1800000000);
                  op_b = 64'sd3600000000; op_dst = 5'd6; end
            7'd3: begin op_unit = UnitRot;
                  op_ang = src_lon[63] ? 32'd0 - v_reg[6][31:0] : v_reg[6][31:0];
                  op_dst = base + 5'd2; end
            7'd4: begin op_a = v_reg[base]; op_b = v_reg[base]; op_dst = 5'd7; end
            7'd5: begin op_a = v_reg[7]; op_b = E2Q36; op_dst = 5'd7; end
            7'd6: begin op_kind = OpSqrt;
                  sat_tmp = (64'sd1 <<< 36) - v_reg[7];
                  op_a = (sat_tmp < 64'sd1) ? (64'sd1 <<< 26) : (sat_tmp <<< 26);
                  op_dst = 5'd7; end
            7'd7: begin op_kind = OpDiv;
                  op_a = signed'((AMm << 31) + (unsigned'(v_reg[7]) >> 1));
                  op_b = v_reg[7]; op_dst = base + 5'd4; end
            7'd8: begin op_a = v_reg[base + 5'd4] + src_alt; op_b = v_reg[base + 5'd1];
                  op_dst = 5'd7; end
            7'd9: begin op_a = v_reg[7]; op_b = v_reg[base + 5'd3];
                  op_dst = base + 5'd5; end
            7'd10: begin op_a = v_reg[7]; op_b = v_reg[base + 5'd2];
                   op_dst = base + 5'd6; end
            7'd11: begin op_a = v_reg[base + 5'd4]; op_b = E2Q36; op_sh = 7'd36;
                   op_dst = 5'd7; end
            7'd12: begin op_a = v_reg[base + 5'd4] - v_reg[7] + src_alt;
                   op_b = v_reg[base]; op_dst = base + 5'd7; end
            7'd13: begin op_a = v_reg[19]; op_b = dy; op_dst = 5'd24; end
            7'd14: begin op_a = v_reg[18]; op_b = dx; op_dst = 5'd25; end
            7'd15: begin op_a = v_reg[19]; op_b = dx; op_dst = 5'd26; end
            7'd16: begin op_a = v_reg[18]; op_b = dy; op_dst = 5'd27; end
            7'd17: begin op_a = v_reg[17]; op_b = dz; op_dst = 5'd28; end
            7'd18: begin op_a = v_reg[16]; op_b = v_reg[26] + v_reg[27]; op_dst = 5'd29; end
            7'd19: begin op_unit = UnitRot; op_ang = {rot_reg, 16'h0000}; op_dst = 5'd30; end
            7'd20: begin op_a = e_off; op_b = v_reg[31]; op_dst = 5'd26; end
            7'd21: begin op_a = n_off; op_b = v_reg[30]; op_dst = 5'd27; end
            7'd22: begin op_a = e_off; op_b = v_reg[30]; op_dst = 5'd8; end
            7'd23: begin op_a = n_off; op_b = v_reg[31]; op_dst = 5'd9; end
            7'd24: begin op_unit = UnitLocal; end
            7'd25: begin op_unit = UnitNorm; end
            7'd26: begin op_unit = UnitVec; op_dst = 5'd16; end
            7'd27: begin op_unit = UnitLocal; end
            7'd28: begin op_unit = UnitRot;
                   op_ang = {v_reg[17][15], v_reg[17][15:0], 15'd0}; op_dst = 5'd18; end
            default: begin op_dst = 5'd0; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_lat_reg <= '0; ref_lon_reg <= '0; ref_alt_reg <= '0;
            off_e_reg <= 24'sd45444; off_n_reg <= 24'sd15302; rot_reg <= 16'sd23312;
            prev_e_reg <= '0; prev_n_reg <= '0;
            st_reg <= S_IDLE; pc_reg <= '0; phase_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            creq <= '0; areq <= '0;
        end else begin
            creq.start <= (st_reg == S_ISSUE) &&
                          ((op_unit == UnitRot) || (op_unit == UnitVec && !still));
            areq.start <= (st_reg == S_ISSUE) && (op_unit == UnitArith);
            if (cfg_wr) begin
                case (cfg_idx)
                    RegRefLat: ref_lat_reg <= cfg_data[30:0];
                    RegRefLon: ref_lon_reg <= cfg_data[31:0];
                    RegRefAlt: ref_alt_reg <= cfg_data[24:0];
                    RegOffE:   off_e_reg   <= cfg_data[23:0];
                    RegOffN:   off_n_reg   <= cfg_data[23:0];
                    RegRot:    rot_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
            case (st_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        v_reg[0] <= 64'(signed'(s_tdata[30:0]));
                        v_reg[1] <= 64'(signed'(s_tdata[62:31]));
                        v_reg[2] <= 64'(signed'(s_tdata[87:63]));
                        v_reg[3] <= 64'(ref_lat_reg);
                        v_reg[4] <= 64'(ref_lon_reg);
                        v_reg[5] <= 64'(ref_alt_reg);
                        pc_reg <= '0;
                        phase_reg <= 1'b0;
                        st_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    case (op_unit)
                        UnitArith: begin
                            areq.kind  <= op_kind;
                            areq.a     <= (op_kind == OpMul) ? mg(op_a) : unsigned'(op_a);
                            areq.b     <= (op_kind == OpMul) ? mg(op_b) : unsigned'(op_b);
                            areq.shift <= op_sh;
                            areq.neg   <= (op_kind == OpMul) && (op_a[63] ^ op_b[63]);
                            st_reg <= S_WAIT;
                        end
                        UnitRot: begin
                            creq.vector_mode <= 1'b0;
                            creq.angle <= op_ang;
                            st_reg <= S_WAIT;
                        end
                        UnitVec: begin
                            if (still) begin
                                pc_reg <= pc_next; st_reg <= st_adv;
                            end else begin
                                creq.vector_mode <= 1'b1;
                                creq.x0 <= v_reg[12];
                                creq.y0 <= v_reg[13];
                                st_reg <= S_WAIT;
                            end
                        end
                        UnitNorm: begin
                            if (!still && norm_or >= 64'd2147483648) begin
                                v_reg[12] <= v_reg[12] >>> 1;
                                v_reg[13] <= v_reg[13] >>> 1;
                            end else if (!still && norm_or < 64'd1073741824) begin
                                v_reg[12] <= v_reg[12] <<< 1;
                                v_reg[13] <= v_reg[13] <<< 1;
                            end else begin
                                pc_reg <= pc_next; st_reg <= st_adv;
                            end
                        end
                        default: begin
                            if (pc_reg == 7'd24) begin
                                v_reg[10] <= xr_w;
                                v_reg[11] <= yr_w;
                                v_reg[12] <= signed'(mg(mx_w));
                                v_reg[13] <= signed'(mg(my_w));
                                v_reg[14] <= mx_w;
                                v_reg[15] <= my_w;
                            end else begin
                                v_reg[17] <= {48'd0, hsum[31:16]};
                            end
                            pc_reg <= pc_next; st_reg <= st_adv;
                        end
                    endcase
                end
                S_WAIT: begin
                    if (cdone) begin
                        if (op_unit == UnitVec) begin
                            v_reg[op_dst] <= cz;
                        end else begin
                            v_reg[op_dst] <= cy; v_reg[op_dst + 5'd1] <= cx;
                        end
                    end
                    if (adone) v_reg[op_dst] <= signed'(ares);
                    if (cdone || adone) begin
                        pc_reg <= pc_next;
                        phase_reg <= phase_reg || (pc_reg == PcPassEnd);
                        st_reg <= st_adv;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_data_reg <= {q15(v_reg[19]), q15(v_reg[18]), v_reg[17][15:0],
                                       v_reg[11][31:0], v_reg[10][31:0]};
                        prev_e_reg <= v_reg[10][31:0];
                        prev_n_reg <= v_reg[11][31:0];
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (st_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second request taken");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> m_valid_reg) else $error("result dropped");
    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(creq.start && areq.start)) else $error("both units started");

endmodule
